// ----- sv/tabs_pkg.sv -----
package tabs_pkg;

  localparam int unsigned MaskW  = 10;
  localparam int unsigned LevelW = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam int unsigned L2RoundW = 15;
  localparam int unsigned L2QuietW = 14;
  localparam int unsigned L3RoundW = 12;

  localparam logic [MaskW-1:0] MaskL1 = 10'h03F;
  localparam logic [MaskW-1:0] MaskL2 = 10'h0C0;
  localparam logic [MaskW-1:0] MaskL3 = 10'h300;

  // Alert level codes; 1 is the most severe.
  localparam logic [LevelW-1:0] LvlNone = 2'd0;
  localparam logic [LevelW-1:0] Lvl1    = 2'd1;
  localparam logic [LevelW-1:0] Lvl2    = 2'd2;
  localparam logic [LevelW-1:0] Lvl3    = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBeeperPresent = 3'd0,
    CfgReportPresent = 3'd1,
    CfgL2OnTicks     = 3'd2,
    CfgL2OffTicks    = 3'd3,
    CfgL3BeepCount   = 3'd4,
    CfgL3RepeatAt    = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]  L2OnTicksRst   = 8'd30;
  localparam logic [13:0] L2OffTicksRst  = 14'd1800;
  localparam logic [3:0]  L3BeepCountRst = 4'd3;
  localparam logic [11:0] L3RepeatAtRst  = 12'd184;

  typedef struct packed {
    logic              beeper_present;
    logic              report_present;
    logic [7:0]        l2_on_ticks;
    logic [13:0]       l2_off_ticks;
    logic [3:0]        l3_beep_count;
    logic [11:0]       l3_repeat_at;
  } cfg_t;

  typedef struct packed {
    logic              beeper_cmd_valid;
    logic [LevelW-1:0] beeper_level;
    logic              beeper_on;
    logic              report_valid;
    logic [MaskW-1:0]  report_mask;
    logic [LevelW-1:0] report_level;
  } result_t;

endpackage

// ----- sv/tabs_if.sv -----
interface tabs_in_if;
  import tabs_pkg::*;
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] active_mask;
  modport source (output valid, output active_mask, input ready);
  modport sink   (input valid, input active_mask, output ready);
endinterface

interface tabs_out_if;
  import tabs_pkg::*;
  logic              valid;
  logic              ready;
  logic              beeper_cmd_valid;
  logic [LevelW-1:0] beeper_level;
  logic              beeper_on;
  logic              report_valid;
  logic [MaskW-1:0]  report_mask;
  logic [LevelW-1:0] report_level;
  modport source (output valid, output beeper_cmd_valid, output beeper_level,
                  output beeper_on, output report_valid, output report_mask,
                  output report_level, input ready);
  modport sink   (input valid, input beeper_cmd_valid, input beeper_level,
                  input beeper_on, input report_valid, input report_mask,
                  input report_level, output ready);
endinterface

interface tabs_cfg_if;
  import tabs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/tiered_alarm_beep_sequencer_top.sv -----
// Channel | dir | payload                                   | transfer when
// cfg_i   | in  | index, data                               | valid & ready (ready tied high)
// in_i    | in  | active_mask                               | valid & ready
// out_o   | out | beeper_cmd_valid/level/on, report_*       | valid & ready
//
// One result per tick item, captured in the result register at the input transfer
// edge, offered on out_o from the next cycle; one item per cycle while out_o is ready.
// The result register decouples the sides: a new item is taken while the
// previous result drains in the same cycle.
// Stall on out_o holds the result and drops in_i.ready until it is taken.
// Reset (rst_ni low, async) clears all round counters and loads register defaults.
module tiered_alarm_beep_sequencer_top
  import tabs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  tabs_cfg_if.sink          cfg_i,
  tabs_in_if.sink           in_i,
  tabs_out_if.source        out_o
);

  cfg_t cfg_q;

  logic [L2RoundW-1:0] l2_round_q, l2_round_d;
  logic [L2QuietW-1:0] l2_quiet_q, l2_quiet_d;
  logic [L3RoundW-1:0] l3_round_q, l3_round_d;

  logic    out_vld_q;
  result_t res_q, res_d;
  logic    in_acc;

  // Config registers: writes always taken, unknown indexes dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beeper_present <= 1'b1;
      cfg_q.report_present <= 1'b1;
      cfg_q.l2_on_ticks    <= L2OnTicksRst;
      cfg_q.l2_off_ticks   <= L2OffTicksRst;
      cfg_q.l3_beep_count  <= L3BeepCountRst;
      cfg_q.l3_repeat_at   <= L3RepeatAtRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgBeeperPresent: cfg_q.beeper_present <= cfg_i.data[0];
        CfgReportPresent: cfg_q.report_present <= cfg_i.data[0];
        CfgL2OnTicks:     cfg_q.l2_on_ticks    <= cfg_i.data[7:0];
        CfgL2OffTicks:    cfg_q.l2_off_ticks   <= cfg_i.data[13:0];
        CfgL3BeepCount:   cfg_q.l3_beep_count  <= cfg_i.data[3:0];
        CfgL3RepeatAt:    cfg_q.l3_repeat_at   <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  // Take a new tick whenever the result slot is empty or draining now.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Per-tick sequencing: most severe level present wins.
  logic [L2RoundW-1:0] l2_inc;
  logic [L3RoundW-1:0] l3_inc;
  logic [4:0]          l3_sil_tick;
  logic                cmd, on, rep;
  logic [LevelW-1:0]   lvl, rlvl;

  assign l2_inc      = l2_round_q + L2RoundW'(1);
  assign l3_inc      = l3_round_q + L3RoundW'(1);
  assign l3_sil_tick = {1'b0, cfg_q.l3_beep_count} + 5'd1;

  always_comb begin
    l2_round_d = l2_round_q;
    l2_quiet_d = l2_quiet_q;
    l3_round_d = l3_round_q;
    cmd  = 1'b0;
    lvl  = LvlNone;
    on   = 1'b0;
    rep  = 1'b0;
    rlvl = LvlNone;

    if (|(in_i.active_mask & MaskL1)) begin
      cmd = 1'b1; lvl = Lvl1; on = 1'b1;
      l3_round_d = '0;
    end else if (|(in_i.active_mask & MaskL2)) begin
      // beeping phase, then quiet phase, then restart with a report
      l2_round_d = l2_inc;
      if (l2_inc <= L2RoundW'(cfg_q.l2_on_ticks)) begin
        on = 1'b1;
      end else if (l2_quiet_q < cfg_q.l2_off_ticks) begin
        l2_quiet_d = l2_quiet_q + L2QuietW'(1);
      end else begin
        l2_round_d = '0;
        l2_quiet_d = '0;
        rep = 1'b1; rlvl = Lvl2;
      end
      cmd = 1'b1; lvl = Lvl2;
      l3_round_d = '0;
    end else if (|(in_i.active_mask & MaskL3)) begin
      // beep ticks, one silence command, then no commands until repeat
      l3_round_d = l3_inc;
      if (l3_inc <= L3RoundW'(cfg_q.l3_beep_count)) begin
        cmd = 1'b1; lvl = Lvl3; on = 1'b1;
      end else if (l3_inc == L3RoundW'(l3_sil_tick)) begin
        cmd = 1'b1; lvl = Lvl3; on = 1'b0;
      end else if (l3_inc >= cfg_q.l3_repeat_at) begin
        l3_round_d = '0;
        rep = 1'b1; rlvl = Lvl3;
      end
    end else begin
      // no alarm: explicit beeper-off command
      cmd = 1'b1; lvl = Lvl1; on = 1'b0;
    end

    if (!cfg_q.beeper_present) cmd = 1'b0;
    if (!cfg_q.report_present) rep = 1'b0;

    res_d.beeper_cmd_valid = cmd;
    res_d.beeper_level     = cmd ? lvl : LvlNone;
    res_d.beeper_on        = cmd & on;
    res_d.report_valid     = rep;
    res_d.report_mask      = rep ? in_i.active_mask : '0;
    res_d.report_level     = rep ? rlvl : LvlNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2_round_q <= '0;
      l2_quiet_q <= '0;
      l3_round_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        l2_round_q <= l2_round_d;
        l2_quiet_q <= l2_quiet_d;
        l3_round_q <= l3_round_d;
        out_vld_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.beeper_cmd_valid = res_q.beeper_cmd_valid;
  assign out_o.beeper_level     = res_q.beeper_level;
  assign out_o.beeper_on        = res_q.beeper_on;
  assign out_o.report_valid     = res_q.report_valid;
  assign out_o.report_mask      = res_q.report_mask;
  assign out_o.report_level     = res_q.report_level;

  // Assertions
  a_acc_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_vld_q)
    else $error("accepted tick did not produce a result");

  a_l1_clears_l3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && |(in_i.active_mask & MaskL1)) |=> (l3_round_q == '0))
    else $error("level 1 tick left level 3 count nonzero");

  a_report_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.report_valid) |->
      (res_q.report_level == Lvl2 || res_q.report_level == Lvl3))
    else $error("report with bad level");

  a_l3_report_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.report_valid && res_q.report_level == Lvl3) |->
      !res_q.beeper_cmd_valid)
    else $error("level 3 report tick also issued a beeper command");

  a_no_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.beeper_cmd_valid) |->
      (res_q.beeper_level == LvlNone && !res_q.beeper_on))
    else $error("beeper fields set without a command");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tabs_pkg::*;

  localparam int unsigned ClkHalf    = 6;
  localparam int unsigned ResetTicks = 10;
  // Slowest legal run is far below this: ~1250 ticks, each with a short send gap
  // and a geometric stall on the result side.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned IdlePct    = 33;

  // Mask classes used to build runs of ticks.
  localparam int unsigned TierNone = 0;
  localparam int unsigned TierL1   = 1;
  localparam int unsigned TierL2   = 2;
  localparam int unsigned TierL3   = 3;

  logic clk;
  logic rst_ni;

  tabs_cfg_if cfg_if ();
  tabs_in_if  in_if ();
  tabs_out_if out_if ();

  tiered_alarm_beep_sequencer_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Register copy and round counters of the alarm sequencer as the bench sees them.
  cfg_t                reg_copy;
  logic [L2RoundW-1:0] l2_round_cnt;
  logic [L2QuietW-1:0] l2_quiet_cnt;
  logic [L3RoundW-1:0] l3_round_cnt;

  // Beeper/report outcomes still owed by the block, oldest first.
  result_t     pending_outcomes[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          steady_flow;   // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Clock, reset, and the watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result-side backpressure: changes at the falling edge only. About a third of
  // cycles stall, except during the steady-flow burst.
  always @(negedge clk) begin
    if (steady_flow) begin
      out_if.ready = 1'b1;
    end else begin
      out_if.ready = ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction: one tick in, one outcome out. Counters wrap at their widths.
  // ---------------------------------------------------------------------------
  function automatic result_t serve_tick(input logic [MaskW-1:0] mask);
    result_t          r;
    logic             cmd;
    logic             on;
    logic             rep;
    logic [LevelW-1:0] lvl;
    logic [LevelW-1:0] rlvl;
    cmd  = 1'b0;
    on   = 1'b0;
    rep  = 1'b0;
    lvl  = LvlNone;
    rlvl = LvlNone;
    if ((mask & MaskL1) != '0) begin
      // Most severe: continuous beep, level-3 round starts over.
      cmd          = 1'b1;
      lvl          = Lvl1;
      on           = 1'b1;
      l3_round_cnt = '0;
    end else if ((mask & MaskL2) != '0) begin
      l2_round_cnt = l2_round_cnt + 1'b1;
      if (l2_round_cnt <= reg_copy.l2_on_ticks) begin
        on = 1'b1;
      end else if (l2_quiet_cnt < reg_copy.l2_off_ticks) begin
        l2_quiet_cnt = l2_quiet_cnt + 1'b1;
      end else begin
        // quiet part done: new round, with a report
        l2_round_cnt = '0;
        l2_quiet_cnt = '0;
        rep          = 1'b1;
        rlvl         = Lvl2;
      end
      cmd          = 1'b1;
      lvl          = Lvl2;
      l3_round_cnt = '0;
    end else if ((mask & MaskL3) != '0) begin
      l3_round_cnt = l3_round_cnt + 1'b1;
      if (l3_round_cnt <= reg_copy.l3_beep_count) begin
        cmd = 1'b1;
        lvl = Lvl3;
        on  = 1'b1;
      end else if (int'(l3_round_cnt) == int'(reg_copy.l3_beep_count) + 1) begin
        // one explicit silence tick after the beeps
        cmd = 1'b1;
        lvl = Lvl3;
      end else if (l3_round_cnt >= reg_copy.l3_repeat_at) begin
        l3_round_cnt = '0;
        rep          = 1'b1;
        rlvl         = Lvl3;
      end
      // waiting ticks: no command at all
    end else begin
      // no alarm: beeper off, counters hold
      cmd = 1'b1;
      lvl = Lvl1;
    end

    if (!reg_copy.beeper_present) cmd = 1'b0;
    if (!cmd) begin
      lvl = LvlNone;
      on  = 1'b0;
    end
    if (!reg_copy.report_present) rep = 1'b0;
    if (!rep) rlvl = LvlNone;

    r.beeper_cmd_valid = cmd;
    r.beeper_level     = lvl;
    r.beeper_on        = on;
    r.report_valid     = rep;
    r.report_mask      = rep ? mask : '0;
    r.report_level     = rlvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every result transfer is matched against the oldest
  // pending outcome, field by field.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result transfer with nothing expected, expected none, got %h",
                 $time, {out_if.beeper_cmd_valid, out_if.beeper_level, out_if.beeper_on,
                         out_if.report_valid, out_if.report_mask, out_if.report_level});
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("beeper_cmd_valid", 32'(want.beeper_cmd_valid),
                      32'(out_if.beeper_cmd_valid));
        compare_field("beeper_level", 32'(want.beeper_level), 32'(out_if.beeper_level));
        compare_field("beeper_on", 32'(want.beeper_on), 32'(out_if.beeper_on));
        compare_field("report_valid", 32'(want.report_valid), 32'(out_if.report_valid));
        compare_field("report_mask", 32'(want.report_mask), 32'(out_if.report_mask));
        compare_field("report_level", 32'(want.report_level), 32'(out_if.report_level));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes at the falling edge; transfers are seen at the
  // rising edge.
  // ---------------------------------------------------------------------------

  // One tick into the block. valid stays high across back-to-back ticks and is
  // only lowered for a random gap or when the block is drained.
  task automatic send_tick(input logic [MaskW-1:0] mask);
    if (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.active_mask = mask;
    do @(posedge clk); while (!in_if.ready);
    pending_outcomes.push_back(serve_tick(mask));
    @(negedge clk);
  endtask

  // Stop sending and wait until every outcome has been taken, plus a margin
  // for the result register.
  task automatic drain;
    in_if.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CfgBeeperPresent: reg_copy.beeper_present = value[0];
      CfgReportPresent: reg_copy.report_present = value[0];
      CfgL2OnTicks:     reg_copy.l2_on_ticks    = value[7:0];
      CfgL2OffTicks:    reg_copy.l2_off_ticks   = value[13:0];
      CfgL3BeepCount:   reg_copy.l3_beep_count  = value[3:0];
      CfgL3RepeatAt:    reg_copy.l3_repeat_at   = value[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Full register set; only called with the block drained.
  task automatic program_regs(input logic beep_en, input logic rep_en,
                              input int unsigned on_t, input int unsigned off_t,
                              input int unsigned beeps, input int unsigned rep_at);
    drain();
    write_reg(CfgBeeperPresent, CfgDataW'(beep_en));
    write_reg(CfgReportPresent, CfgDataW'(rep_en));
    write_reg(CfgL2OnTicks, CfgDataW'(on_t));
    write_reg(CfgL2OffTicks, CfgDataW'(off_t));
    write_reg(CfgL3BeepCount, CfgDataW'(beeps));
    write_reg(CfgL3RepeatAt, CfgDataW'(rep_at));
  endtask

  // Small random registers so rounds close often; enables mostly on.
  task automatic program_small_random;
    program_regs($urandom_range(0, 99) < 80, $urandom_range(0, 99) < 80,
                 $urandom_range(0, 8), $urandom_range(0, 10),
                 $urandom_range(0, 6), $urandom_range(0, 25));
  endtask

  // A mask whose most severe level is the given tier; lower-severity bits are
  // mixed in where they do not change the tier.
  function automatic logic [MaskW-1:0] draw_mask(input int unsigned tier);
    logic [MaskW-1:0] m;
    m = '0;
    case (tier)
      TierL1: begin
        m = MaskW'($urandom_range(0, 1023));
        if ((m & MaskL1) == '0) m[4'($urandom_range(0, 5))] = 1'b1;
      end
      TierL2: begin
        m[9:8] = 2'($urandom_range(0, 3));
        m[7:6] = 2'($urandom_range(1, 3));
      end
      TierL3: m[9:8] = 2'($urandom_range(1, 3));
      default: m = '0;
    endcase
    return m;
  endfunction

  // Mostly runs of one tier long enough to walk through whole rounds, broken
  // up by short interruptions and fully random noise ticks.
  task automatic run_random_ticks(input int unsigned count);
    int unsigned sent;
    int unsigned tier;
    int unsigned run_len;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      tier = TierL2;
      else if (pick < 70) tier = TierL3;
      else if (pick < 85) tier = TierL1;
      else                tier = TierNone;
      run_len = (tier == TierL2 || tier == TierL3) ? $urandom_range(1, 40)
                                                   : $urandom_range(1, 5);
      for (int unsigned k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(0, 99) < 10) send_tick(MaskW'($urandom_range(0, 1023)));
        else                            send_tick(draw_mask(tier));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset register values: every level, mask extremes, each single-bit group.
  task automatic test_levels_at_reset;
    send_tick(10'h000);
    send_tick(10'h3FF);
    send_tick(10'h001);
    send_tick(10'h020);
    send_tick(10'h040);
    send_tick(10'h080);
    send_tick(10'h300);
    send_tick(10'h100);
    send_tick(10'h200);
  endtask

  // All timing registers zero: level-2 ticks are all quiet and each one closes
  // the round; level-3 starts with the silence tick; the repeat point sits
  // below the beep part.
  task automatic test_zero_timing;
    program_regs(1'b1, 1'b1, 0, 0, 0, 0);
    repeat (3) send_tick(10'h0C0);
    repeat (4) send_tick(10'h100);
  endtask

  // Repeat point at the beep count: beeps and silence win, restart right after.
  task automatic test_short_repeat;
    program_regs(1'b1, 1'b1, 2, 1, 2, 2);
    repeat (5) send_tick(10'h200);
  endtask

  // Beeper and report disabled: counters still run, outputs stay zero.
  task automatic test_outputs_disabled;
    program_regs(1'b0, 1'b0, 1, 0, 1, 3);
    send_tick(10'h0C0);
    send_tick(10'h080);
    send_tick(10'h000);
  endtask

  // Random rounds under several register settings, extremes among them.
  task automatic test_random_rounds;
    for (int unsigned phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       program_regs(1'b1, 1'b1, 255, 16383, 15, 4095);
        3:       program_regs(1'b1, 1'b1, 1, 1, 1, 17);
        default: program_small_random();
      endcase
      run_random_ticks(200);
    end
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back;
    program_small_random();
    steady_flow = 1'b1;
    run_random_ticks(200);
    drain();
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.active_mask = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CfgBeeperPresent;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    steady_flow       = 1'b0;
    mismatch_cnt      = 0;
    cycle_cnt         = 0;

    reg_copy.beeper_present = 1'b1;
    reg_copy.report_present = 1'b1;
    reg_copy.l2_on_ticks    = L2OnTicksRst;
    reg_copy.l2_off_ticks   = L2OffTicksRst;
    reg_copy.l3_beep_count  = L3BeepCountRst;
    reg_copy.l3_repeat_at   = L3RepeatAtRst;
    l2_round_cnt = '0;
    l2_quiet_cnt = '0;
    l3_round_cnt = '0;

    repeat (ResetTicks) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_levels_at_reset();
    test_zero_timing();
    test_short_repeat();
    test_outputs_disabled();
    test_random_rounds();
    test_back_to_back();

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tabs_pkg.sv
sv/tabs_if.sv
sv/tiered_alarm_beep_sequencer_top.sv
bench/testbench.sv
